FILE: rtl/core/lqm_pkg.sv
// ----------------------------------------------------------------------------
// lqm_pkg: shared types and constants of the linear queue with minimum
// Holds the queue depth, field widths, opcode and status codes, the
// transaction payload structs and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lqm_pkg;

    // Queue geometry.
    localparam int DEPTH       = 8;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W       = $clog2(DEPTH + 1);

    // Fixed field widths of the transaction payloads.
    localparam int VALUE_W     = 32;
    localparam int OCC_FIELD_W = 4;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_LIST = 2'd2
    } opcode_t;

    // Status codes carried by a response.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Which kind of response the datapath builds.
    typedef enum logic [2:0] {
        EMIT_OK,
        EMIT_FULL,
        EMIT_EMPTY,
        EMIT_ITEM,
        EMIT_LIST
    } emit_kind_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEQ_DATA,
        S_SCAN_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_LIST_RD,
        S_LIST_EMIT,
        S_EMIT
    } state_t;

    // Request payload.
    typedef struct packed {
        opcode_t                     opcode;
        logic signed [VALUE_W-1:0]   push_value;
    } req_t;

    // Response payload.
    typedef struct packed {
        status_t                     status;
        logic signed [VALUE_W-1:0]   out_value;
        logic [OCC_FIELD_W-1:0]      occupancy;
        logic signed [VALUE_W-1:0]   smallest;
        logic                        last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        logic       enq;
        logic       deq_adv;
        logic       item_load;
        logic       rd_en;
        logic       rd_head;
        logic       idx_init;
        logic       idx_inc;
        logic       min_cmp;
        logic       emit;
        emit_kind_t emit_kind;
        logic       emit_last;
    } lqm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    empty;
        logic    head_eq_tail;
        logic    idx_at_tail;
        logic    out_free;
    } lqm_stat_t;

endpackage

FILE: rtl/core/lqm_ctrl.sv
// ----------------------------------------------------------------------------
// lqm_ctrl: sequencer of the linear queue with minimum
// Accepts one request at a time, steps the datapath through the memory
// reads of a dequeue, a minimum rescan or a listing, and issues responses.
// ----------------------------------------------------------------------------
module lqm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  lqm_pkg::lqm_stat_t stat,
    output lqm_pkg::lqm_cmd_t  cmd
);

    lqm_pkg::state_t     state_reg, state_next;
    lqm_pkg::emit_kind_t kind_reg, kind_next;

    // State and pending response kind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lqm_pkg::S_IDLE;
            kind_reg  <= lqm_pkg::EMIT_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.emit_kind = kind_reg;

        unique case (state_reg)
            lqm_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = lqm_pkg::S_DECODE;
                end
            end

            lqm_pkg::S_DECODE:
            begin
                case (stat.op)
                    lqm_pkg::OP_ENQ:
                    begin
                        if (stat.full)
                        begin
                            kind_next = lqm_pkg::EMIT_FULL;
                        end
                        else
                        begin
                            cmd.enq   = 1'b1;
                            kind_next = lqm_pkg::EMIT_OK;
                        end
                        state_next = lqm_pkg::S_EMIT;
                    end
                    lqm_pkg::OP_DEQ:
                    begin
                        if (stat.empty)
                        begin
                            kind_next  = lqm_pkg::EMIT_EMPTY;
                            state_next = lqm_pkg::S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_head = 1'b1;
                            state_next  = lqm_pkg::S_DEQ_DATA;
                        end
                    end
                    lqm_pkg::OP_LIST:
                    begin
                        if (stat.empty)
                        begin
                            kind_next  = lqm_pkg::EMIT_EMPTY;
                            state_next = lqm_pkg::S_EMIT;
                        end
                        else
                        begin
                            cmd.idx_init = 1'b1;
                            state_next   = lqm_pkg::S_LIST_RD;
                        end
                    end
                    default:
                    begin
                        // The unused opcode produces no response.
                        state_next = lqm_pkg::S_IDLE;
                    end
                endcase
            end

            lqm_pkg::S_DEQ_DATA:
            begin
                // Head data is back: keep it and retire the element.
                cmd.item_load = 1'b1;
                cmd.deq_adv   = 1'b1;
                kind_next     = lqm_pkg::EMIT_ITEM;
                if (stat.head_eq_tail)
                begin
                    state_next = lqm_pkg::S_EMIT;
                end
                else
                begin
                    state_next = lqm_pkg::S_SCAN_START;
                end
            end

            lqm_pkg::S_SCAN_START:
            begin
                cmd.idx_init = 1'b1;
                state_next   = lqm_pkg::S_SCAN_RD;
            end

            lqm_pkg::S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = lqm_pkg::S_SCAN_CMP;
            end

            lqm_pkg::S_SCAN_CMP:
            begin
                cmd.min_cmp = 1'b1;
                if (stat.idx_at_tail)
                begin
                    state_next = lqm_pkg::S_EMIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = lqm_pkg::S_SCAN_RD;
                end
            end

            lqm_pkg::S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = lqm_pkg::S_LIST_EMIT;
            end

            lqm_pkg::S_LIST_EMIT:
            begin
                cmd.emit_kind = lqm_pkg::EMIT_LIST;
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = stat.idx_at_tail;
                    if (stat.idx_at_tail)
                    begin
                        state_next = lqm_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = lqm_pkg::S_LIST_RD;
                    end
                end
            end

            lqm_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = lqm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lqm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/lqm_dp.sv
// ----------------------------------------------------------------------------
// lqm_dp: datapath of the linear queue with minimum
// Slot memory with one registered read port, head and tail pointers,
// running minimum, scan index and the response output register.
// ----------------------------------------------------------------------------
module lqm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  lqm_pkg::req_t      req,
    input  lqm_pkg::lqm_cmd_t  cmd,
    output lqm_pkg::lqm_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lqm_pkg::rsp_t      rsp
);

    localparam logic [lqm_pkg::PTR_W-1:0] LAST_SLOT = lqm_pkg::PTR_W'(lqm_pkg::DEPTH - 1);

    // Slot storage.
    logic signed [lqm_pkg::VALUE_W-1:0] slots [lqm_pkg::DEPTH];

    // Control state.
    logic [lqm_pkg::PTR_W-1:0] head_reg, head_next;
    logic [lqm_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic                      nonempty_reg, nonempty_next;
    logic                      out_valid_reg, out_valid_next;

    // Payload state.
    lqm_pkg::opcode_t                   op_reg;
    logic signed [lqm_pkg::VALUE_W-1:0] val_reg;
    logic signed [lqm_pkg::VALUE_W-1:0] min_reg, min_next;
    logic signed [lqm_pkg::VALUE_W-1:0] rd_data_reg;
    logic signed [lqm_pkg::VALUE_W-1:0] item_reg;
    logic [lqm_pkg::PTR_W-1:0]          idx_reg, idx_next;
    lqm_pkg::rsp_t                      out_reg, out_next;

    logic [lqm_pkg::PTR_W-1:0] wr_addr;
    logic [lqm_pkg::PTR_W-1:0] rd_addr;
    logic [lqm_pkg::OCC_W-1:0] occ;

    // Addresses and occupancy.
    assign wr_addr = nonempty_reg ? tail_reg + 1'b1 : '0;
    assign rd_addr = cmd.rd_head ? head_reg : idx_reg;
    assign occ     = nonempty_reg
                   ? lqm_pkg::OCC_W'({1'b0, tail_reg} - {1'b0, head_reg}) + 1'b1
                   : '0;

    // Status to the controller.
    always_comb
    begin
        stat.op           = op_reg;
        stat.full         = nonempty_reg && (tail_reg == LAST_SLOT);
        stat.empty        = !nonempty_reg;
        stat.head_eq_tail = (head_reg == tail_reg);
        stat.idx_at_tail  = (idx_reg == tail_reg);
        stat.out_free     = !out_valid_reg || rsp_ready;
    end

    // Pointer, minimum and index updates.
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        min_next      = min_reg;
        idx_next      = idx_reg;

        if (cmd.enq)
        begin
            if (nonempty_reg)
            begin
                tail_next = tail_reg + 1'b1;
                if (val_reg < min_reg)
                begin
                    min_next = val_reg;
                end
            end
            else
            begin
                head_next     = '0;
                tail_next     = '0;
                nonempty_next = 1'b1;
                min_next      = val_reg;
            end
        end

        if (cmd.deq_adv)
        begin
            if (head_reg == tail_reg)
            begin
                head_next     = '0;
                tail_next     = '0;
                nonempty_next = 1'b0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
        end

        // The first scanned element seeds the minimum.
        if (cmd.min_cmp)
        begin
            if ((idx_reg == head_reg) || (rd_data_reg < min_reg))
            begin
                min_next = rd_data_reg;
            end
        end

        if (cmd.idx_init)
        begin
            idx_next = head_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Response assembly.
    always_comb
    begin
        out_next           = out_reg;
        out_next.occupancy = lqm_pkg::OCC_FIELD_W'(occ);
        out_next.smallest  = nonempty_reg ? min_reg : '0;
        out_next.last      = cmd.emit_last;
        out_next.out_value = '0;
        case (cmd.emit_kind)
            lqm_pkg::EMIT_FULL:  out_next.status = lqm_pkg::STATUS_FULL;
            lqm_pkg::EMIT_EMPTY: out_next.status = lqm_pkg::STATUS_EMPTY;
            default:             out_next.status = lqm_pkg::STATUS_OK;
        endcase
        case (cmd.emit_kind)
            lqm_pkg::EMIT_ITEM: out_next.out_value = item_reg;
            lqm_pkg::EMIT_LIST: out_next.out_value = rd_data_reg;
            default:            out_next.out_value = '0;
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            nonempty_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        idx_reg <= idx_next;
        if (cmd.load_req)
        begin
            op_reg  <= req.opcode;
            val_reg <= req.push_value;
        end
        if (cmd.item_load)
        begin
            item_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            slots[wr_addr] <= val_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // An empty queue always sits with both pointers on the first slot.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with pointers off slot zero");

    // The head never passes the tail while elements are held.
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        nonempty_reg |-> (head_reg <= tail_reg))
        else $error("head pointer beyond tail pointer");

    // A response is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || rsp_ready))
        else $error("response overwrote a pending transaction");

    // An accepted enqueue leaves the queue non-empty.
    a_enq_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |=> nonempty_reg)
        else $error("queue empty after enqueue");

endmodule

FILE: rtl/core/linear_queue_with_min_core.sv
// ----------------------------------------------------------------------------
// linear_queue_with_min_core: non-circular array queue with running minimum
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (opcode, push_value) with req_valid/req_ready.
//   Responses leave on rsp (status, out_value, occupancy, smallest, last)
//   with rsp_valid/rsp_ready. One request is worked on at a time.
//   Enqueue, a full enqueue, or a dequeue/listing of an empty queue: the
//   request is decoded and the response is then registered; the next
//   request is taken only once that response has been loaded.
//   Dequeue: the head element is read and retired; when elements are left,
//   the minimum is then rescanned element by element through the single
//   read port of the slot memory.
//   Listing: one memory read and one response for each element, after the
//   request is taken and decoded.
//   Opcode 3 produces no response.
//   Reset leaves the queue empty with both pointers on the first slot; the
//   slot memory is not cleared. When the receiver stalls, the finished
//   response waits in the output register while the next request can still
//   be taken; a further response holds the sequencer until the register
//   frees, and req_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module linear_queue_with_min_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lqm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lqm_pkg::rsp_t rsp
);

    lqm_pkg::lqm_cmd_t  cmd;
    lqm_pkg::lqm_stat_t stat;

    // Sequencer.
    lqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, pointers and response register.
    lqm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
